@@ design/alarm_report_frame_builder_top_macros.svh @@
// Assertion macros shared by the frame builder.
`ifndef ALARM_REPORT_FRAME_BUILDER_TOP_MACROS_SVH
`define ALARM_REPORT_FRAME_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define ARFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define ARFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ARFB_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARFB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ design/arfb_pkg.sv @@
`default_nettype none

package arfb_pkg;

    // Input operation codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_ADDR = 2'd0;
    localparam logic [1:0] CFG_MAJOR    = 2'd1;
    localparam logic [1:0] CFG_USER     = 2'd2;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd3;

    localparam logic [47:0] SRC_ADDR_RST = 48'd0;
    localparam logic [7:0]  MAJOR_RST    = 8'h01;
    localparam logic [7:0]  USER_RST     = 8'h10;
    localparam logic [10:0] MAX_LEN_RST  = 11'd1024;

    // Command kinds passed from the front end to the back end.
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // Byte positions inside a frame sequence.
    localparam logic [4:0] IDX_FIRST    = 5'd0;
    localparam logic [4:0] IDX_SUM_LO   = 5'd2;
    localparam logic [4:0] IDX_SER_HI   = 5'd3;
    localparam logic [4:0] IDX_MAJOR    = 5'd4;
    localparam logic [4:0] IDX_USER     = 5'd5;
    localparam logic [4:0] IDX_TS_LO    = 5'd6;
    localparam logic [4:0] IDX_TS_HI    = 5'd11;
    localparam logic [4:0] IDX_SRC_LO   = 5'd12;
    localparam logic [4:0] IDX_SRC_HI   = 5'd17;
    localparam logic [4:0] IDX_DST_LO   = 5'd18;
    localparam logic [4:0] IDX_DST_HI   = 5'd23;
    localparam logic [4:0] IDX_LEN_LO   = 5'd24;
    localparam logic [4:0] IDX_LEN_HI   = 5'd25;
    localparam logic [4:0] IDX_BODY     = 5'd26;
    localparam logic [4:0] IDX_CHECKSUM = 5'd27;
    localparam logic [4:0] IDX_TRAIL_A  = 5'd28;
    localparam logic [4:0] IDX_TRAIL_B  = 5'd29;

    localparam logic [7:0] START_BYTE = 8'h40;
    localparam logic [7:0] TRAIL_BYTE = 8'h23;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        opcode;
        logic        use_counter;
        logic [15:0] serial_in;
        logic [7:0]  command_byte;
        logic [47:0] time_stamp;
        logic [9:0]  payload_length;
        logic [7:0]  payload_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic        rejected;
        logic [15:0] serial_used;
    } t_out_item;

    typedef struct packed {
        logic [47:0] src_addr;
        logic [7:0]  major_version;
        logic [7:0]  user_version;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic        trail;
        logic [15:0] serial;
        logic [7:0]  command_byte;
        logic [47:0] time_stamp;
        logic [9:0]  payload_length;
        logic [7:0]  payload_byte;
    } t_cmd;

endpackage

`default_nettype wire

@@ design/arfb_front.sv @@
`default_nettype none

// Tracks the open frame, picks serial numbers and turns each item into a command, but drops payload outside a frame.
module arfb_front #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire arfb_pkg::t_in_item i_item,
    input  wire logic [10:0]      i_max_len,
    output arfb_pkg::t_cmd        o_cmd,
    output logic                  o_cmd_push
);

    logic        r_open, n_open;
    logic [9:0]  r_left, n_left;
    logic [15:0] r_counter, n_counter;
    logic [15:0] r_serial, n_serial;
    logic [15:0] cnt_inc;
    logic        too_long;

    always_comb begin
        cnt_inc  = r_counter + 16'd1;
        too_long = ({1'b0, i_item.payload_length} >= i_max_len)
                || (32'(i_item.payload_length) >= MAX_PAYLOAD);

        n_open     = r_open;
        n_left     = r_left;
        n_counter  = r_counter;
        n_serial   = r_serial;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        o_cmd.command_byte   = i_item.command_byte;
        o_cmd.time_stamp     = i_item.time_stamp;
        o_cmd.payload_length = i_item.payload_length;
        o_cmd.payload_byte   = i_item.payload_byte;

        if (i_accept) begin
            if (i_item.opcode == arfb_pkg::OP_PAYLOAD) begin
                if (r_open) begin
                    o_cmd_push  = 1'b1;
                    o_cmd.kind  = arfb_pkg::KIND_PAYLOAD;
                    o_cmd.trail = (r_left == 10'd1);
                    o_cmd.serial = r_serial;
                    n_left = r_left - 10'd1;
                    if (r_left == 10'd1) begin
                        n_open = 1'b0;
                    end
                end
            end else begin
                if (i_item.use_counter) begin
                    n_counter = (cnt_inc == 16'd0) ? 16'd1 : cnt_inc;
                    n_serial  = n_counter;
                end else begin
                    n_serial = i_item.serial_in;
                end
                o_cmd_push   = 1'b1;
                o_cmd.serial = n_serial;
                if (too_long) begin
                    o_cmd.kind = arfb_pkg::KIND_REJECT;
                    n_open = 1'b0;
                    n_left = '0;
                end else begin
                    o_cmd.kind  = arfb_pkg::KIND_START;
                    o_cmd.trail = (i_item.payload_length == 10'd0);
                    n_open = (i_item.payload_length != 10'd0);
                    n_left = i_item.payload_length;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_left    <= '0;
            r_counter <= '0;
            r_serial  <= '0;
        end else begin
            r_open    <= n_open;
            r_left    <= n_left;
            r_counter <= n_counter;
            r_serial  <= n_serial;
        end
    end

endmodule

`default_nettype wire

@@ design/arfb_queue.sv @@
`default_nettype none

// Small command queue between the front end and the back end.
module arfb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire arfb_pkg::t_cmd i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output arfb_pkg::t_cmd      o_data,
    output logic                o_empty
);

    localparam int PTR_W = $clog2(arfb_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(arfb_pkg::QUEUE_DEPTH + 1);

    arfb_pkg::t_cmd   r_mem [arfb_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(arfb_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/arfb_back.sv @@
`default_nettype none

// Expands the command at the queue head into frame bytes, one per cycle while the output register is free.
module arfb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire arfb_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    input  wire arfb_pkg::t_cfg i_cfg,
    output arfb_pkg::t_out_item o_item,
    output logic                o_empty,
    input  wire logic           i_pop
);

    logic                r_mid;
    logic [4:0]          r_idx;
    logic [7:0]          r_sum;
    logic                r_valid;
    arfb_pkg::t_out_item r_out;

    logic       step, last, summed, is_rej;
    logic [4:0] idx;
    logic [4:0] ts_off, src_off;
    logic [7:0] cur_byte;

    always_comb begin
        is_rej = (i_cmd.kind == arfb_pkg::KIND_REJECT);
        if (r_mid) begin
            idx = r_idx;
        end else if (i_cmd.kind == arfb_pkg::KIND_START) begin
            idx = arfb_pkg::IDX_FIRST;
        end else begin
            idx = arfb_pkg::IDX_BODY;
        end
        ts_off  = idx - arfb_pkg::IDX_TS_LO;
        src_off = idx - arfb_pkg::IDX_SRC_LO;

        case (idx) inside
            arfb_pkg::IDX_SUM_LO:   cur_byte = i_cmd.serial[7:0];
            arfb_pkg::IDX_SER_HI:   cur_byte = i_cmd.serial[15:8];
            arfb_pkg::IDX_MAJOR:    cur_byte = i_cfg.major_version;
            arfb_pkg::IDX_USER:     cur_byte = i_cfg.user_version;
            [arfb_pkg::IDX_TS_LO:arfb_pkg::IDX_TS_HI]:
                cur_byte = i_cmd.time_stamp[{ts_off[2:0], 3'b000} +: 8];
            [arfb_pkg::IDX_SRC_LO:arfb_pkg::IDX_SRC_HI]:
                cur_byte = i_cfg.src_addr[{src_off[2:0], 3'b000} +: 8];
            [arfb_pkg::IDX_DST_LO:arfb_pkg::IDX_DST_HI]:
                cur_byte = 8'h00;
            arfb_pkg::IDX_LEN_LO:   cur_byte = i_cmd.payload_length[7:0];
            arfb_pkg::IDX_LEN_HI:   cur_byte = {6'd0, i_cmd.payload_length[9:8]};
            arfb_pkg::IDX_BODY: begin
                if (i_cmd.kind == arfb_pkg::KIND_START) begin
                    cur_byte = i_cmd.command_byte;
                end else begin
                    cur_byte = i_cmd.payload_byte;
                end
            end
            arfb_pkg::IDX_CHECKSUM: cur_byte = r_sum;
            arfb_pkg::IDX_TRAIL_A,
            arfb_pkg::IDX_TRAIL_B:  cur_byte = arfb_pkg::TRAIL_BYTE;
            default:                cur_byte = arfb_pkg::START_BYTE;
        endcase
        if (is_rej) begin
            cur_byte = 8'h00;
        end

        summed = !is_rej && (idx >= arfb_pkg::IDX_SUM_LO) && (idx <= arfb_pkg::IDX_BODY);
        last   = is_rej || (idx == arfb_pkg::IDX_TRAIL_B)
              || ((idx == arfb_pkg::IDX_BODY) && !i_cmd.trail);
        step   = i_cmd_valid && (!r_valid || i_pop);
    end

    assign o_cmd_pop = step && last;
    assign o_item    = r_out;
    assign o_empty   = !r_valid;

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.frame_byte  <= cur_byte;
            r_out.frame_end   <= is_rej || (idx == arfb_pkg::IDX_TRAIL_B);
            r_out.rejected    <= is_rej;
            r_out.serial_used <= i_cmd.serial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mid   <= 1'b0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                r_mid   <= !last;
                r_idx   <= idx + 5'd1;
                if (!is_rej && (i_cmd.kind == arfb_pkg::KIND_START)
                        && (idx == arfb_pkg::IDX_FIRST)) begin
                    r_sum <= 8'h00;
                end else if (summed) begin
                    r_sum <= r_sum + cur_byte;
                end
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/alarm_report_frame_builder_top.sv @@
// Alarm report frame builder: turns start and payload items into a byte stream.
// Input channel: drive i_in_item and raise push; the item is taken at an edge where
// push is high and full is low. A start item (opcode 0) carries the serial choice,
// command, six-byte time stamp and payload length; each payload item carries one byte.
// Result channel: while empty is low, o_out_item holds the oldest frame byte; it is
// taken at an edge where pop is high. A start emits 27 header bytes (30 when the
// length is zero), each payload byte emits one byte, and the last one adds the
// checksum and two trailer bytes. An over-long start emits one rejected item.
// The command of an accepted item enters the queue at the accepting edge and its first
// result is then registered, when the back end is idle and the output register is free.
// Throughput: while pop is high, the back end sends one byte per cycle, so payload items
// are accepted one per cycle; during a header burst the four-entry command queue fills
// and full rises until the header drains.
// When the receiver stalls, the output register holds its item and the queue absorbs
// up to four further commands before full is raised.
// Reset (synchronous, active low) empties the queue and output, closes any frame,
// clears the frame counter and loads the configuration registers with their defaults.
// The user writes configuration (i_cfg_we, i_cfg_idx, i_cfg_data) only while idle; the block does not enforce it.
`default_nettype none
`include "alarm_report_frame_builder_top_macros.svh"

module alarm_report_frame_builder_top #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire arfb_pkg::t_in_item i_in_item,
    output logic                    empty,
    input  wire logic               pop,
    output arfb_pkg::t_out_item     o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [47:0]        i_cfg_data
);

    arfb_pkg::t_cfg r_cfg;
    logic [10:0]    r_max_len;

    arfb_pkg::t_cmd front_cmd, head_cmd;
    logic           front_push, q_empty, q_pop;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_addr      <= arfb_pkg::SRC_ADDR_RST;
            r_cfg.major_version <= arfb_pkg::MAJOR_RST;
            r_cfg.user_version  <= arfb_pkg::USER_RST;
            r_max_len           <= arfb_pkg::MAX_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arfb_pkg::CFG_SRC_ADDR: r_cfg.src_addr      <= i_cfg_data;
                arfb_pkg::CFG_MAJOR:    r_cfg.major_version <= i_cfg_data[7:0];
                arfb_pkg::CFG_USER:     r_cfg.user_version  <= i_cfg_data[7:0];
                arfb_pkg::CFG_MAX_LEN:  r_max_len           <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Front end: frame bookkeeping and classification of each accepted item.
    arfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_item     (i_in_item),
        .i_max_len  (r_max_len),
        .o_cmd      (front_cmd),
        .o_cmd_push (front_push)
    );

    // Command queue decouples item intake from byte generation.
    arfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (head_cmd),
        .o_empty (q_empty)
    );

    // Back end: byte sequencer, checksum and output register.
    arfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (q_pop),
        .i_cfg       (r_cfg),
        .o_item      (o_out_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // The front end only issues commands for items it actually accepted.
    `ARFB_ASSERT(a_push_room, i_clk, i_rst_n, front_push |-> !full, "command pushed into full queue")
    // The back end retires a command only when one is waiting.
    `ARFB_ASSERT(a_pop_valid, i_clk, i_rst_n, q_pop |-> !q_empty, "command retired from empty queue")
    // A rejection is always a single, final result.
    `ARFB_ASSERT(a_rej_end, i_clk, i_rst_n, (!empty && o_out_item.rejected) |-> o_out_item.frame_end, "rejected result without frame end")
    // Nothing is offered right after reset.
    `ARFB_ASSERT_ALWAYS(a_rst_empty, i_clk, $past(!i_rst_n) |-> empty, "result visible after reset")

endmodule

`default_nettype wire

@@ tb/alarm_report_frame_builder_top_tb.sv @@
`default_nettype none

module alarm_report_frame_builder_top_tb;

    import arfb_pkg::*;

    // The payload bound the block is built for; lengths at or above it are refused.
    localparam int FRAME_MAX_PAYLOAD = 1024;
    // Generous bound on the whole run.
    localparam int CYCLE_LIMIT       = 1_000_000;
    // The first result of an item passes the command queue and the output register, so the
    // extra settle cycles after the last expected byte cover an item that made no result.
    localparam int SETTLE_CYCLES     = 8;
    // One long receiver stall, long enough for the command queue to fill up.
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int ITEMS_PER_PHASE   = 64;
    localparam int NUM_PHASES        = 6;
    localparam int MAX_ERR_PRINTS    = 30;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_e;

    // One line of the directed table. A typed_count of -1 leaves the expectation to
    // the frame predictor; 0 or 1 means the row carries its own expected result.
    typedef struct {
        row_kind_e   kind;
        t_in_item    item;
        int          typed_count;
        t_out_item   typed;
        logic [1:0]  cfg_idx;
        logic [47:0] cfg_data;
    } stim_row_t;

    // Every input of the block starts at a known value.
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        push       = 1'b0;
    logic        full;
    t_in_item    i_in_item  = '0;
    logic        empty;
    logic        pop        = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = CFG_SRC_ADDR;
    logic [47:0] i_cfg_data = '0;

    alarm_report_frame_builder_top #(
        .MAX_PAYLOAD(FRAME_MAX_PAYLOAD)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in_item (i_in_item),
        .empty     (empty),
        .pop       (pop),
        .o_out_item(o_out_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers, updated at the write edge.
    logic [47:0] cfg_src;
    logic [7:0]  cfg_major;
    logic [7:0]  cfg_user;
    logic [10:0] cfg_max_len;

    // Shadow copy of the frame builder state.
    logic        fm_open;
    logic [9:0]  fm_left;
    logic [7:0]  fm_sum;
    logic [15:0] fm_counter;
    logic [15:0] fm_serial;

    // Bytes produced by the item being predicted, and the frame bytes still owed.
    t_out_item step_bytes[$];
    t_out_item expected_bytes[$];
    stim_row_t directed_rows[$];

    int  cycle_count      = 0;
    int  error_count      = 0;
    int  items_sent       = 0;
    int  ignored_count    = 0;
    int  results_checked  = 0;
    int  rejects_seen     = 0;
    int  frames_closed    = 0;
    int  frames_abandoned = 0;
    int  burst_left       = 0;
    bit  random_phase     = 1'b0;
    bit  hold_done        = 1'b0;

    // ------------------------------------------------------------------
    // Frame predictor
    // ------------------------------------------------------------------

    function automatic void emit_byte(logic [7:0] value, logic fin, logic rej);
        t_out_item r;
        r.frame_byte  = value;
        r.frame_end   = fin;
        r.rejected    = rej;
        r.serial_used = fm_serial;
        step_bytes.push_back(r);
    endfunction

    // Every byte from the serial number up to the body byte goes into the checksum.
    function automatic void emit_summed(logic [7:0] value);
        fm_sum = fm_sum + value;
        emit_byte(value, 1'b0, 1'b0);
    endfunction

    // Checksum, then the two trailer bytes; the second one closes the frame.
    function automatic void emit_trailer();
        emit_byte(fm_sum, 1'b0, 1'b0);
        emit_byte(TRAIL_BYTE, 1'b0, 1'b0);
        emit_byte(TRAIL_BYTE, 1'b1, 1'b0);
        fm_open = 1'b0;
        fm_left = '0;
        frames_closed++;
    endfunction

    function automatic void frame_builder_step(t_in_item it);
        logic [9:0] len;
        step_bytes.delete();
        len = it.payload_length;

        // A payload byte passes through only while a frame is open.
        if (it.opcode == OP_PAYLOAD) begin
            if (fm_open) begin
                emit_summed(it.payload_byte);
                fm_left = fm_left - 10'd1;
                if (fm_left == 10'd0) emit_trailer();
            end
            return;
        end

        // A start drops any open frame without a trailer.
        if (fm_open) frames_abandoned++;
        fm_open = 1'b0;
        fm_left = '0;
        fm_sum  = '0;

        // The internal counter skips zero when it wraps.
        if (it.use_counter) begin
            fm_counter = fm_counter + 16'd1;
            if (fm_counter == 16'd0) fm_counter = 16'd1;
            fm_serial = fm_counter;
        end else begin
            fm_serial = it.serial_in;
        end

        if ({1'b0, len} >= cfg_max_len || int'(len) >= FRAME_MAX_PAYLOAD) begin
            emit_byte(8'h00, 1'b1, 1'b1);
            rejects_seen++;
            return;
        end

        emit_byte(START_BYTE, 1'b0, 1'b0);
        emit_byte(START_BYTE, 1'b0, 1'b0);
        emit_summed(fm_serial[7:0]);
        emit_summed(fm_serial[15:8]);
        emit_summed(cfg_major);
        emit_summed(cfg_user);
        for (int i = 0; i < 6; i++) emit_summed(it.time_stamp[8*i +: 8]);
        for (int i = 0; i < 6; i++) emit_summed(cfg_src[8*i +: 8]);
        for (int i = 0; i < 6; i++) emit_summed(8'h00);
        emit_summed(len[7:0]);
        emit_summed({6'd0, len[9:8]});
        emit_summed(it.command_byte);

        fm_open = 1'b1;
        if (len == 10'd0) emit_trailer();
        else fm_left = len;
    endfunction

    function automatic void apply_config(logic [1:0] idx, logic [47:0] data);
        case (idx)
            CFG_SRC_ADDR: cfg_src     = data;
            CFG_MAJOR:    cfg_major   = data[7:0];
            CFG_USER:     cfg_user    = data[7:0];
            CFG_MAX_LEN:  cfg_max_len = data[10:0];
            default:      ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (expected_bytes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_ERR_PRINTS)
                $display("%0t: expected none, got byte %02h end %0b rej %0b serial %04h",
                         $time, got.frame_byte, got.frame_end, got.rejected, got.serial_used);
            return;
        end
        want = expected_bytes.pop_front();
        results_checked++;
        if (got.frame_byte !== want.frame_byte || got.frame_end !== want.frame_end ||
            got.rejected !== want.rejected || got.serial_used !== want.serial_used) begin
            error_count++;
            if (error_count <= MAX_ERR_PRINTS)
                $display("%0t: expected %02h/%0b/%0b/%04h, got %02h/%0b/%0b/%04h",
                         $time, want.frame_byte, want.frame_end, want.rejected,
                         want.serial_used, got.frame_byte, got.frame_end, got.rejected,
                         got.serial_used);
        end
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    // Unused fields carry random values so that every input bit toggles.
    function automatic t_in_item random_start(logic cnt, logic [9:0] len);
        t_in_item it;
        it.opcode         = OP_START;
        it.use_counter    = cnt;
        it.serial_in      = 16'($urandom);
        it.command_byte   = 8'($urandom);
        it.time_stamp     = 48'({$urandom, $urandom});
        it.payload_length = len;
        it.payload_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item random_payload();
        t_in_item it;
        it = random_start(1'($urandom), 10'($urandom));
        it.opcode = OP_PAYLOAD;
        return it;
    endfunction

    function automatic void add_start(logic cnt, logic [15:0] ser, logic [7:0] cmd,
                                      logic [47:0] ts, logic [9:0] len, bit typed_reject);
        stim_row_t row;
        row = '{kind: ROW_ITEM, item: '0, typed_count: -1, typed: '0,
                cfg_idx: CFG_SRC_ADDR, cfg_data: '0};
        row.item.opcode         = OP_START;
        row.item.use_counter    = cnt;
        row.item.serial_in      = ser;
        row.item.command_byte   = cmd;
        row.item.time_stamp     = ts;
        row.item.payload_length = len;
        // A refused start gives exactly one flagged byte carrying the serial.
        if (typed_reject) begin
            row.typed_count       = 1;
            row.typed.frame_byte  = 8'h00;
            row.typed.frame_end   = 1'b1;
            row.typed.rejected    = 1'b1;
            row.typed.serial_used = ser;
        end
        directed_rows.push_back(row);
    endfunction

    function automatic void add_payload(logic [7:0] value, bit typed_ignored);
        stim_row_t row;
        row = '{kind: ROW_ITEM, item: '0, typed_count: -1, typed: '0,
                cfg_idx: CFG_SRC_ADDR, cfg_data: '0};
        row.item.opcode       = OP_PAYLOAD;
        row.item.payload_byte = value;
        if (typed_ignored) row.typed_count = 0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [47:0] data);
        directed_rows.push_back('{kind: ROW_CFG, item: '0, typed_count: -1, typed: '0,
                                  cfg_idx: idx, cfg_data: data});
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one item and waits for the edge that takes it. The sender runs in
    // bursts of random length; push stays high between items of one burst.
    task automatic send_item(input t_in_item it, input int typed_count, input t_out_item typed);
        int gap;
        bit ignored;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);

        ignored = (it.opcode == OP_PAYLOAD) && !fm_open;
        frame_builder_step(it);
        if (typed_count < 0) begin
            foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
        end else if (typed_count > 0) begin
            expected_bytes.push_back(typed);
        end
        if (ignored) ignored_count++;
        else items_sent++;
    endtask

    // Registers change only while the block is idle: every owed byte has arrived
    // and a payload item that made no result has had time to pass through.
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_config(idx, data);
    endtask

    // Narrow registers get random upper bits, which the block must drop.
    task automatic program_phase(input logic [47:0] src, input logic [7:0] major,
                                 input logic [7:0] user, input logic [10:0] max_len);
        logic [47:0] noise;
        noise = 48'({$urandom, $urandom});
        settle();
        write_reg(CFG_SRC_ADDR, src);
        write_reg(CFG_MAJOR, {noise[47:8], major});
        write_reg(CFG_USER, {noise[39:0], user});
        write_reg(CFG_MAX_LEN, {noise[36:0], max_len});
        i_cfg_we <= 1'b0;
    endtask

    // One frame-shaped sequence: a start, then mostly the right number of payload
    // bytes. Some frames are cut short and dropped by the next start, some starts
    // are refused, and a few stray payload bytes follow now and then.
    task automatic random_frame();
        logic [9:0] len;
        int         cap;
        int         r;
        int         nbytes;
        t_out_item  none;
        none = '0;
        cap = int'(cfg_max_len) - 1;
        if (cap > FRAME_MAX_PAYLOAD - 1) cap = FRAME_MAX_PAYLOAD - 1;
        r = $urandom_range(0, 99);
        if (cap < 0) len = 10'($urandom_range(0, 1023));
        else if (r < 65) len = 10'($urandom_range(0, (cap < 12) ? cap : 12));
        else if (r < 80) len = 10'($urandom_range(0, (cap < 40) ? cap : 40));
        else if (r < 92 && cap < 1023) len = 10'($urandom_range(cap + 1, 1023));
        else len = 10'($urandom_range(0, 1023));

        send_item(random_start(1'($urandom), len), -1, none);

        if (!fm_open) nbytes = 0;
        else if (len > 10'd40) nbytes = $urandom_range(0, 20);
        else if ($urandom_range(0, 9) == 0) nbytes = $urandom_range(0, int'(len) - 1);
        else nbytes = int'(len);

        for (int i = 0; i < nbytes; i++) send_item(random_payload(), -1, none);
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) send_item(random_payload(), -1, none);
    endtask

    // ------------------------------------------------------------------
    // Receiver: pops on a pattern of its own, with one long hold-off once the
    // random part has begun so that the block backs up and raises full.
    // ------------------------------------------------------------------

    initial begin
        rx_mode_e mode;
        int       mode_left;
        int       tick;
        int       hold_left;
        mode      = RX_STREAM;
        mode_left = 0;
        tick      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_result(o_out_item);
            tick++;
            if (random_phase && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    RX_STREAM: pop <= 1'b1;
                    RX_RANDOM: pop <= 1'($urandom_range(0, 1));
                    default:   pop <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes still owed.",
                     cycle_count, expected_bytes.size());
            $display("alarm_report_frame_builder_top_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        bit        cfg_active;
        int        phase_start;
        t_out_item none;
        none = '0;

        // Shadow state matches the block after reset.
        cfg_src     = SRC_ADDR_RST;
        cfg_major   = MAJOR_RST;
        cfg_user    = USER_RST;
        cfg_max_len = MAX_LEN_RST;
        fm_open     = 1'b0;
        fm_left     = '0;
        fm_sum      = '0;
        fm_counter  = '0;
        fm_serial   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, with reset defaults first. A payload byte with no open
        // frame must vanish; an empty payload gives the whole frame from the start.
        add_payload(8'h5A, 1'b1);
        add_start(1'b1, 16'h0000, 8'h02, 48'h0, 10'd0, 1'b0);
        add_start(1'b0, 16'hFFFF, 8'hFF, 48'hFFFF_FFFF_FFFF, 10'd3, 1'b0);
        add_payload(8'h00, 1'b0);
        add_payload(8'hFF, 1'b0);
        add_payload(8'hA5, 1'b0);
        // The longest accepted length opens a frame that the next start abandons.
        add_start(1'b0, 16'h1234, 8'h03, 48'h0123_4567_89AB, 10'd1023, 1'b0);
        add_payload(8'h11, 1'b0);
        add_start(1'b1, 16'h0000, 8'h05, 48'h0000_0000_0001, 10'd2, 1'b0);
        add_payload(8'h80, 1'b0);
        add_payload(8'h7F, 1'b0);
        add_payload(8'hC3, 1'b1);
        // A small length limit and extreme header registers.
        add_cfg(CFG_MAX_LEN, 48'd4);
        add_cfg(CFG_SRC_ADDR, 48'hFFFF_FFFF_FFFF);
        add_cfg(CFG_MAJOR, 48'hFF);
        add_cfg(CFG_USER, 48'h00);
        add_start(1'b0, 16'hBEEF, 8'h02, 48'h0, 10'd4, 1'b1);
        add_start(1'b0, 16'h0001, 8'h02, 48'h0, 10'd1023, 1'b1);
        add_start(1'b1, 16'h0000, 8'h06, 48'hA5A5_5A5A_A5A5, 10'd3, 1'b0);
        add_payload(8'h01, 1'b0);
        add_payload(8'hFE, 1'b0);
        add_payload(8'h5A, 1'b0);
        // A zero limit refuses every start, even an empty one.
        add_cfg(CFG_MAX_LEN, 48'd0);
        add_start(1'b0, 16'h0000, 8'h00, 48'h0, 10'd0, 1'b1);
        add_payload(8'hFF, 1'b1);

        cfg_active = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!cfg_active) settle();
                write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_data);
                cfg_active = 1'b1;
            end else begin
                if (cfg_active) i_cfg_we <= 1'b0;
                cfg_active = 1'b0;
                send_item(directed_rows[i].item, directed_rows[i].typed_count,
                          directed_rows[i].typed);
            end
        end

        // Random part over several register settings, the extremes among them.
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: program_phase(48'({$urandom, $urandom}), 8'h00, 8'hFF, 11'd2047);
                1: program_phase(48'hFFFF_FFFF_FFFF, 8'hFF, 8'h00, 11'd1);
                2: program_phase(48'h0, 8'($urandom), 8'($urandom), 11'd1024);
                3: program_phase(48'({$urandom, $urandom}), 8'($urandom), 8'($urandom),
                                 11'($urandom_range(2, 40)));
                4: program_phase(48'({$urandom, $urandom}), 8'($urandom), 8'($urandom),
                                 11'd12);
                default: program_phase(48'({$urandom, $urandom}), MAJOR_RST, USER_RST,
                                       MAX_LEN_RST);
            endcase
            random_phase = 1'b1;
            phase_start  = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) random_frame();
        end

        // Drain, then give stray results time to show up.
        settle();

        $display("Sent %0d items plus %0d stray payload bytes; %0d result bytes checked.",
                 items_sent, ignored_count, results_checked);
        $display("%0d register settings: %0d frames closed, %0d abandoned, %0d refused.",
                 NUM_PHASES + 3, frames_closed, frames_abandoned, rejects_seen);
        if (error_count == 0) begin
            $display("alarm_report_frame_builder_top_tb: PASS");
        end else begin
            $display("%0d failures.", error_count);
            $display("alarm_report_frame_builder_top_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
